// ===== src/swfr_pkg.sv =====
package swfr_pkg;

   localparam int MAX_FRAME_BYTES = 1024;
   localparam int RAW_W = $clog2(MAX_FRAME_BYTES + 1);

   localparam logic [7:0] FLAG_BYTE     = 8'h7E;
   localparam logic [7:0] ESC_BYTE      = 8'h7D;
   localparam logic [7:0] ESC_FLAG_BYTE = 8'h5E;
   localparam logic [7:0] ESC_ESC_BYTE  = 8'h5D;
   localparam logic [7:0] CTRL_SEQ0     = 8'h00;
   localparam logic [7:0] CTRL_SEQ1     = 8'h40;
   localparam logic [7:0] ADDRESS_RESET = 8'h03;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
   localparam logic [1:0] VERDICT_REJECT    = 2'd1;
   localparam logic [1:0] VERDICT_DUPLICATE = 2'd2;
   localparam logic [1:0] VERDICT_DISCARD   = 2'd3;

   localparam logic [1:0] REPLY_NONE = 2'd0;
   localparam logic [1:0] REPLY_RR   = 2'd1;
   localparam logic [1:0] REPLY_REJ  = 2'd2;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] payload_byte;
      logic [1:0] verdict;
      logic [1:0] reply_kind;
      logic       reply_seq;
   } rsp_type;

endpackage

// ===== src/stop_and_wait_frame_receiver.sv =====
// Stop-and-wait frame receiver. Takes one raw link byte per request and
// returns at most one result per request: a destuffed payload byte (emitted
// one byte late, so BCC2 and the closing flag never appear as payload) or,
// at frame end, a verdict with any RR/REJ reply to send and the updated
// sequence bit. A frame opens on the first byte after the previous one
// closed and closes on a raw 0x7E or after MAX_FRAME_BYTES raw bytes.
// Each byte is decoded combinationally into the result register, so a new
// request is taken every clock; a two-entry output buffer (result register
// plus skid register) keeps input flowing while one result waits, and
// req_stall rises only when both are full. Payload bytes of bad frames are
// still emitted; the verdict says whether to keep them. The user must write
// csr_address_byte only while the block is idle; this is not enforced.
module stop_and_wait_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_verdict,
   output logic [1:0] rsp_reply_kind,
   output logic       rsp_reply_seq,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_address_byte
);

   localparam logic [2:0] IDX_FLAG = 3'd0;
   localparam logic [2:0] IDX_ADDR = 3'd1;
   localparam logic [2:0] IDX_CTRL = 3'd2;
   localparam logic [2:0] IDX_BCC1 = 3'd3;
   localparam logic [2:0] IDX_FULL = 3'd5;
   localparam logic [swfr_pkg::RAW_W-1:0] RAW_LIMIT =
      swfr_pkg::RAW_W'(swfr_pkg::MAX_FRAME_BYTES);

   logic [7:0] address_ff;

   logic                       in_frame_ff, in_frame_in;
   logic [swfr_pkg::RAW_W-1:0] raw_count_ff, raw_count_in;
   logic [2:0]                 out_index_ff, out_index_in;
   logic                       escape_pending_ff, escape_pending_in;
   logic [1:0]                 header_code_ff, header_code_in;
   logic                       header_decided_ff, header_decided_in;
   logic [7:0]                 addr_seen_ff, addr_seen_in;
   logic [7:0]                 ctrl_seen_ff, ctrl_seen_in;
   logic                       expected_seq_ff, expected_seq_in;
   logic [7:0]                 data_xor_ff, data_xor_in;
   logic [7:0]                 held_byte_ff, held_byte_in;
   logic                       held_valid_ff, held_valid_in;

   swfr_pkg::rsp_type out_ff, skid_ff, result;
   logic              out_valid_ff, skid_valid_ff;

   logic       accept, pop, push, opening, closing, have;
   logic [7:0] x, d, want;

   // frame state as seen by this byte (a new frame starts from clear)
   logic [2:0] cur_out_index;
   logic       cur_escape, cur_header_decided, cur_held_valid;
   logic [1:0] cur_header_code;
   logic [7:0] cur_addr, cur_ctrl, cur_xor, cur_held;

   assign accept    = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign x         = req_rx_byte;

   always_comb begin
      opening = !in_frame_ff;
      raw_count_in = opening ? swfr_pkg::RAW_W'(1) : raw_count_ff + swfr_pkg::RAW_W'(1);
      closing = !opening && ((x == swfr_pkg::FLAG_BYTE) || (raw_count_in >= RAW_LIMIT));

      cur_out_index      = opening ? 3'd0 : out_index_ff;
      cur_escape         = opening ? 1'b0 : escape_pending_ff;
      cur_header_code    = opening ? 2'd0 : header_code_ff;
      cur_header_decided = opening ? 1'b0 : header_decided_ff;
      cur_addr           = opening ? 8'd0 : addr_seen_ff;
      cur_ctrl           = opening ? 8'd0 : ctrl_seen_ff;
      cur_xor            = opening ? 8'd0 : data_xor_ff;
      cur_held           = opening ? 8'd0 : held_byte_ff;
      cur_held_valid     = opening ? 1'b0 : held_valid_ff;

      out_index_in      = cur_out_index;
      header_code_in    = cur_header_code;
      header_decided_in = cur_header_decided;
      addr_seen_in      = cur_addr;
      ctrl_seen_in      = cur_ctrl;
      data_xor_in       = cur_xor;
      held_byte_in      = cur_held;
      held_valid_in     = cur_held_valid;
      expected_seq_in   = expected_seq_ff;
      in_frame_in       = 1'b1;
      escape_pending_in = 1'b0;

      have = 1'b0;
      d    = 8'd0;
      if (cur_escape) begin
         d    = (x == swfr_pkg::ESC_FLAG_BYTE) ? swfr_pkg::FLAG_BYTE : swfr_pkg::ESC_BYTE;
         have = 1'b1;
      end else if (x == swfr_pkg::ESC_BYTE) begin
         if (closing) begin
            d    = swfr_pkg::ESC_BYTE;
            have = 1'b1;
         end else begin
            escape_pending_in = 1'b1;
         end
      end else begin
         d    = x;
         have = 1'b1;
      end

      push   = 1'b0;
      result = '0;
      want   = expected_seq_ff ? swfr_pkg::CTRL_SEQ1 : swfr_pkg::CTRL_SEQ0;

      if (!closing) begin
         if (have) begin
            case (cur_out_index)
               IDX_FLAG: begin
                  if (d != swfr_pkg::FLAG_BYTE) header_code_in[0] = 1'b1;
               end
               IDX_ADDR: addr_seen_in = d;
               IDX_CTRL: ctrl_seen_in = d;
               IDX_BCC1: begin
                  if (d != (cur_addr ^ cur_ctrl)) header_code_in[1] = 1'b1;
                  header_decided_in = 1'b1;
               end
               default: begin
                  if (cur_held_valid) begin
                     push                = 1'b1;
                     result.out_kind     = swfr_pkg::KIND_PAYLOAD;
                     result.payload_byte = cur_held;
                     data_xor_in         = cur_xor ^ cur_held;
                  end
                  held_byte_in  = d;
                  held_valid_in = 1'b1;
               end
            endcase
            if (cur_out_index < IDX_FULL) out_index_in = cur_out_index + 3'd1;
         end
      end else begin
         in_frame_in       = 1'b0;
         push              = 1'b1;
         result.out_kind   = swfr_pkg::KIND_VERDICT;
         result.verdict    = swfr_pkg::VERDICT_DISCARD;
         result.reply_kind = swfr_pkg::REPLY_NONE;
         if (cur_out_index < IDX_FULL || !cur_held_valid || !cur_header_decided) begin
            result.verdict = swfr_pkg::VERDICT_DISCARD;
         end else if (cur_header_code[0] || (cur_addr != address_ff)) begin
            result.verdict = swfr_pkg::VERDICT_DISCARD;
         end else if (cur_ctrl != swfr_pkg::CTRL_SEQ0 && cur_ctrl != swfr_pkg::CTRL_SEQ1) begin
            result.verdict = swfr_pkg::VERDICT_DISCARD;
         end else if (cur_ctrl != want) begin
            result.verdict    = swfr_pkg::VERDICT_DUPLICATE;
            result.reply_kind = swfr_pkg::REPLY_RR;
         end else begin
            expected_seq_in = !expected_seq_ff;
            if (cur_header_code[1] || (cur_held != cur_xor)) begin
               result.verdict    = swfr_pkg::VERDICT_REJECT;
               result.reply_kind = swfr_pkg::REPLY_REJ;
            end else if (d != swfr_pkg::FLAG_BYTE) begin
               result.verdict = swfr_pkg::VERDICT_DISCARD;
            end else begin
               result.verdict    = swfr_pkg::VERDICT_ACCEPT;
               result.reply_kind = swfr_pkg::REPLY_RR;
            end
         end
         result.reply_seq = expected_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff        <= swfr_pkg::ADDRESS_RESET;
         in_frame_ff       <= 1'b0;
         raw_count_ff      <= '0;
         out_index_ff      <= '0;
         escape_pending_ff <= 1'b0;
         header_code_ff    <= '0;
         header_decided_ff <= 1'b0;
         held_valid_ff     <= 1'b0;
         expected_seq_ff   <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) address_ff <= csr_address_byte;
         if (accept) begin
            in_frame_ff       <= in_frame_in;
            raw_count_ff      <= raw_count_in;
            out_index_ff      <= out_index_in;
            escape_pending_ff <= escape_pending_in;
            header_code_ff    <= header_code_in;
            header_decided_ff <= header_decided_in;
            held_valid_ff     <= held_valid_in;
            expected_seq_ff   <= expected_seq_in;
         end
         if (skid_valid_ff) begin
            if (pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && push) begin
            if (!out_valid_ff || pop) begin
               out_ff       <= result;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_seen_ff <= addr_seen_in;
         ctrl_seen_ff <= ctrl_seen_in;
         data_xor_ff  <= data_xor_in;
         held_byte_ff <= held_byte_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_ff.out_kind;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_verdict      = out_ff.verdict;
   assign rsp_reply_kind   = out_ff.reply_kind;
   assign rsp_reply_seq    = out_ff.reply_seq;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   a_raw_count_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (raw_count_ff != '0 && raw_count_ff < RAW_LIMIT))
      else $error("raw byte count out of range in open frame");

   a_out_index_sat: assert property (@(posedge clock) disable iff (reset)
      out_index_ff <= IDX_FULL)
      else $error("destuffed byte index beyond saturation");

   a_held_implies_full: assert property (@(posedge clock) disable iff (reset)
      (in_frame_ff && held_valid_ff) |-> (out_index_ff == IDX_FULL && header_decided_ff))
      else $error("held payload byte before header complete");

   a_close_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && closing) |=> !in_frame_ff)
      else $error("frame still open after closing byte");

endmodule
